/* src/sobel_pkg.sv */
// sobel_pkg: shared types, widths and register codes of the sobel edge block
// no dependencies; taken in by the interfaces, the lane, the ram user and the top level
package sobel_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int WIDTH_W   = 11;
   localparam int HEIGHT_W  = 16;
   localparam int CHAN_W    = 8;
   localparam int PIX_W     = 3 * CHAN_W;
   localparam int GRAD_W    = 11;
   localparam int SUMSQ_W   = 21;
   localparam int NUM_LANES = 3;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(1024);
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(768);
   localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = WIDTH_W'(3);
   localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
   localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = HEIGHT_W'(3);

   // one channel of the 3x3 neighborhood, [row][col], row 0 on top
   typedef logic [2:0][2:0][CHAN_W-1:0] win_type;

endpackage

/* src/sobel_ifs.sv */
// sobel_ifs: valid/ready channel interfaces for pixels, results and register writes
// depends on sobel_pkg
interface sobel_req_if;
   logic                        valid;
   logic                        ready;
   logic [sobel_pkg::CHAN_W-1:0] red_in;
   logic [sobel_pkg::CHAN_W-1:0] green_in;
   logic [sobel_pkg::CHAN_W-1:0] blue_in;
   modport source (output valid, red_in, green_in, blue_in, input ready);
   modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface sobel_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sobel_pkg::COL_W-1:0]    center_col;
   logic [sobel_pkg::HEIGHT_W-1:0] center_row;
   logic [sobel_pkg::CHAN_W-1:0]   mag_red;
   logic [sobel_pkg::CHAN_W-1:0]   mag_green;
   logic [sobel_pkg::CHAN_W-1:0]   mag_blue;
   logic                          frame_done;
   modport source (output valid, center_col, center_row, mag_red, mag_green, mag_blue,
                   frame_done, input ready);
   modport sink   (input valid, center_col, center_row, mag_red, mag_green, mag_blue,
                   frame_done, output ready);
endinterface

interface sobel_csr_if;
   logic                            valid;
   logic                            ready;
   logic [sobel_pkg::CSR_IDX_W-1:0]  index;
   logic [sobel_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* src/sobel_ram.sv */
// sobel_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
module sobel_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* src/sobel_lane.sv */
// sobel_lane: sobel x/y gradients, sum of squares and bit-serial integer root of one channel
// depends on sobel_pkg
module sobel_lane (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  sobel_pkg::win_type         win,
   output logic [sobel_pkg::CHAN_W-1:0] mag,
   output logic                       mag_valid
);
   import sobel_pkg::*;

   localparam logic [1:0] LN_IDLE   = 2'd0;
   localparam logic [1:0] LN_SQUARE = 2'd1;
   localparam logic [1:0] LN_ROOT   = 2'd2;

   logic [1:0]               state_ff, state_in;
   logic signed [GRAD_W-1:0] gx_ff, gx_in, gy_ff, gy_in;
   logic [SUMSQ_W-1:0]       sumsq_ff, sumsq_in;
   logic [CHAN_W-1:0]        root_ff, root_in, bit_ff, bit_in;
   logic                     valid_ff, valid_in;

   logic signed [GRAD_W-1:0]   v [3][3];
   logic signed [GRAD_W-1:0]   gx_calc, gy_calc;
   logic signed [2*GRAD_W-1:0] sq_x, sq_y;
   logic [CHAN_W-1:0]          trial;
   logic [2*CHAN_W-1:0]        trial_sq;

   // widen the window bytes to signed gradient width
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            v[i][j] = $signed({{(GRAD_W-CHAN_W){1'b0}}, win[i][j]});
         end
      end
   end

   assign gx_calc = (v[0][2] - v[0][0]) + ((v[1][2] - v[1][0]) <<< 1) + (v[2][2] - v[2][0]);
   assign gy_calc = (v[2][0] - v[0][0]) + ((v[2][1] - v[0][1]) <<< 1) + (v[2][2] - v[0][2]);

   assign sq_x     = gx_ff * gx_ff;
   assign sq_y     = gy_ff * gy_ff;
   assign trial    = root_ff | bit_ff;
   assign trial_sq = trial * trial;

   // lane sequencer: gradients, squares, then one root bit per cycle
   always_comb begin
      state_in = state_ff;
      gx_in    = gx_ff;
      gy_in    = gy_ff;
      sumsq_in = sumsq_ff;
      root_in  = root_ff;
      bit_in   = bit_ff;
      valid_in = valid_ff;
      unique case (state_ff)
         LN_IDLE: begin
            if (start) begin
               gx_in    = gx_calc;
               gy_in    = gy_calc;
               valid_in = 1'b0;
               state_in = LN_SQUARE;
            end
         end
         LN_SQUARE: begin
            sumsq_in = sq_x[SUMSQ_W-1:0] + sq_y[SUMSQ_W-1:0];
            root_in  = '0;
            bit_in   = {1'b1, {(CHAN_W-1){1'b0}}};
            state_in = LN_ROOT;
         end
         LN_ROOT: begin
            if ({{(SUMSQ_W-2*CHAN_W){1'b0}}, trial_sq} <= sumsq_ff) begin
               root_in = trial;
            end
            bit_in = bit_ff >> 1;
            if (bit_ff[0]) begin
               valid_in = 1'b1;
               state_in = LN_IDLE;
            end
         end
         default: begin
            state_in = LN_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LN_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      gx_ff    <= gx_in;
      gy_ff    <= gy_in;
      sumsq_ff <= sumsq_in;
      root_ff  <= root_in;
      bit_ff   <= bit_in;
   end

   assign mag       = root_ff;
   assign mag_valid = valid_ff;
endmodule

/* src/sobel_rgb_edge_magnitude_top.sv */
// sobel_rgb_edge_magnitude_top: 3x3 sobel gradient magnitude over an rgb raster stream
// depends on sobel_pkg, sobel_ifs, sobel_ram and sobel_lane
//
// Usage:
//   req_ch carries one rgb pixel per item in raster order. rsp_ch gives one item for
//   each interior pixel (column and row of the window center, per-channel magnitude
//   saturated to 255, frame_done on the last interior pixel of the frame); border
//   pixels give no item. csr_ch writes image_width (index 0) and image_height (index 1);
//   it is always ready; the user must write it only while the block is idle, which the
//   block itself does not enforce. Widths are clamped to 3..1024, heights to at least 3.
// Processing:
//   a border pixel passes through the calc state only; an interior pixel then waits
//   in the root state for the three per-lane root units (one per channel, side by side),
//   which resolve one result bit per cycle; no new pixel is taken until its result is
//   in the output register. The line stores sit in one ram with a registered read port.
// Reset:
//   synchronous; counters and the window clear, registers go to 1024 x 768. The line
//   stores are not cleared: the first two rows rewrite them before they are used.
// Stall:
//   the output register holds an item until rsp_ch.ready; the next pixel is accepted
//   meanwhile, and its result waits in the lanes until the register frees up.
module sobel_rgb_edge_magnitude_top (
   input  logic              clock,
   input  logic              reset,
   sobel_req_if.sink         req_ch,
   sobel_rsp_if.source       rsp_ch,
   sobel_csr_if.sink         csr_ch
);
   import sobel_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CALC = 2'd1;
   localparam logic [1:0] ST_ROOT = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [WIDTH_W-1:0]  width_ff, width_in;
   logic [HEIGHT_W-1:0] height_ff, height_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [HEIGHT_W-1:0] row_ff, row_in;
   logic [PIX_W-1:0]    pix_ff, pix_in;
   logic [PIX_W-1:0]    win_ff [6];
   logic [PIX_W-1:0]    win_in [6];
   logic [COL_W-1:0]    ctr_col_ff, ctr_col_in;
   logic [HEIGHT_W-1:0] ctr_row_ff, ctr_row_in;
   logic                done_ff, done_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]    rsp_col_ff, rsp_col_in;
   logic [HEIGHT_W-1:0] rsp_row_ff, rsp_row_in;
   logic [CHAN_W-1:0]   rsp_mag_ff [NUM_LANES];
   logic [CHAN_W-1:0]   rsp_mag_in [NUM_LANES];
   logic                rsp_done_ff, rsp_done_in;

   logic [WIDTH_W-1:0]  w_eff;
   logic [HEIGHT_W-1:0] h_eff;
   logic [COL_W-1:0]    col_norm;
   logic [HEIGHT_W-1:0] row_norm;
   logic                req_fire;
   logic                out_free;
   logic [WIDTH_W-1:0]  col_inc;
   logic [HEIGHT_W:0]   row_inc;

   logic                ram_wr_en;
   logic [2*PIX_W-1:0]  ram_rd_data;
   logic [PIX_W-1:0]    up_px, mid_px;

   logic                lane_start;
   win_type             lane_win [NUM_LANES];
   logic [CHAN_W-1:0]   lane_mag [NUM_LANES];
   logic [NUM_LANES-1:0] lane_valid;

   // effective frame bounds
   always_comb begin
      if (width_ff < WIDTH_MIN) begin
         w_eff = WIDTH_MIN;
      end else if (width_ff > WIDTH_MAX) begin
         w_eff = WIDTH_MAX;
      end else begin
         w_eff = width_ff;
      end
      h_eff = (height_ff < HEIGHT_MIN) ? HEIGHT_MIN : height_ff;
   end

   // counters restart when the bounds shrank below them
   assign col_norm = ({1'b0, col_ff} >= w_eff) ? '0 : col_ff;
   assign row_norm = (row_ff >= h_eff) ? '0 : row_ff;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign csr_ch.ready = 1'b1;

   // line stores: upper in the high half, middle in the low half
   assign up_px  = ram_rd_data[2*PIX_W-1:PIX_W];
   assign mid_px = ram_rd_data[PIX_W-1:0];
   assign ram_wr_en = (state_ff == ST_CALC);

   sobel_ram #(
      .WIDTH (2 * PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (col_ff),
      .wr_data ({mid_px, pix_ff}),
      .rd_en   (req_fire),
      .rd_addr (col_norm),
      .rd_data (ram_rd_data)
   );

   // per-channel neighborhoods for the lanes
   assign lane_start = (state_ff == ST_CALC) && (col_ff >= COL_W'(2))
                       && (row_ff >= HEIGHT_W'(2));

   always_comb begin
      for (int k = 0; k < NUM_LANES; k++) begin
         for (int i = 0; i < 3; i++) begin
            lane_win[k][i][0] = win_ff[i][CHAN_W*k +: CHAN_W];
            lane_win[k][i][1] = win_ff[3+i][CHAN_W*k +: CHAN_W];
         end
         lane_win[k][0][2] = up_px[CHAN_W*k +: CHAN_W];
         lane_win[k][1][2] = mid_px[CHAN_W*k +: CHAN_W];
         lane_win[k][2][2] = pix_ff[CHAN_W*k +: CHAN_W];
      end
   end

   for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
      sobel_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .start     (lane_start),
         .win       (lane_win[k]),
         .mag       (lane_mag[k]),
         .mag_valid (lane_valid[k])
      );
   end

   assign col_inc = {1'b0, col_ff} + WIDTH_W'(1);
   assign row_inc = {1'b0, row_ff} + (HEIGHT_W+1)'(1);

   // register writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            REG_IMAGE_WIDTH:  width_in  = csr_ch.data[WIDTH_W-1:0];
            REG_IMAGE_HEIGHT: height_in = csr_ch.data[HEIGHT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // item sequencer, window shift and merge into the output register
   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      pix_in       = pix_ff;
      win_in       = win_ff;
      ctr_col_in   = ctr_col_ff;
      ctr_row_in   = ctr_row_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_mag_in   = rsp_mag_ff;
      rsp_done_in  = rsp_done_ff;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               col_in   = col_norm;
               row_in   = row_norm;
               pix_in   = {req_ch.blue_in, req_ch.green_in, req_ch.red_in};
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            ctr_col_in = col_ff - COL_W'(1);
            ctr_row_in = row_ff - HEIGHT_W'(1);
            done_in    = ({1'b0, col_ff} == w_eff - WIDTH_W'(1))
                         && (row_ff == h_eff - HEIGHT_W'(1));
            win_in[0] = win_ff[3];
            win_in[1] = win_ff[4];
            win_in[2] = win_ff[5];
            win_in[3] = up_px;
            win_in[4] = mid_px;
            win_in[5] = pix_ff;
            if (col_inc >= w_eff) begin
               col_in = '0;
               row_in = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[HEIGHT_W-1:0];
            end else begin
               col_in = col_inc[COL_W-1:0];
            end
            state_in = lane_start ? ST_ROOT : ST_IDLE;
         end
         ST_ROOT: begin
            if ((&lane_valid) && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_col_in   = ctr_col_ff;
               rsp_row_in   = ctr_row_ff;
               rsp_mag_in   = lane_mag;
               rsp_done_in  = done_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
         win_ff       <= win_in;
      end
      pix_ff      <= pix_in;
      ctr_col_ff  <= ctr_col_in;
      ctr_row_ff  <= ctr_row_in;
      done_ff     <= done_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_mag_ff  <= rsp_mag_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.center_col = rsp_col_ff;
   assign rsp_ch.center_row = rsp_row_ff;
   assign rsp_ch.mag_red    = rsp_mag_ff[0];
   assign rsp_ch.mag_green  = rsp_mag_ff[1];
   assign rsp_ch.mag_blue   = rsp_mag_ff[2];
   assign rsp_ch.frame_done = rsp_done_ff;
endmodule
